>>> hdl/hermite_spline_animator_assert.svh
// Assertion macros used by the block's top module.
`ifndef HERMITE_SPLINE_ANIMATOR_ASSERT_SVH
`define HERMITE_SPLINE_ANIMATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define HSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define HSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hsa_pkg.sv
package hsa_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int KNOT_WORDS     = 6;
  localparam int DIV_W          = 53;
  localparam int DIV_CW         = 6;
  localparam int FRAC_W         = 16;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] EV_MOVING  = 2'd0;
  localparam logic [1:0] EV_STARTED = 2'd1;
  localparam logic [1:0] EV_STOPPED = 2'd2;

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_DURATION    = 2'd1;
  localparam logic [1:0] CFG_UPDATE_VEL  = 2'd2;

  localparam logic [4:0]  POINT_COUNT_RST = 5'd2;
  localparam logic [31:0] DURATION_RST    = 32'd1000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

endpackage

>>> hdl/hermite_spline_animator.sv
// A knot write stores six words in the knot memory; a start goes through the emit state to the output register.
// A tick inside the curve runs the 53-step shared divider, then
// 12 read-multiply-accumulate passes (read, multiply, accumulate) over the knot memory.
// A tick at the end reads the end knot, and with end velocity also runs three 53-step divides.
// One item at a time; a result waiting in the output register does not block input.
// Reset (async, active low) idles the block and loads register defaults; knot memory is not cleared.
module hermite_spline_animator #(
  parameter int MAX_POINTS = hsa_pkg::MAX_POINTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_index[3:0], pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, now_ticks, 4 zero bits
  input  logic [231:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z, vel_x, vel_y, vel_z
  output logic [191:0] m_axis_tdata,
  // event_res[1:0], vel_valid[2]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import hsa_pkg::*;

  localparam int DEPTH = MAX_POINTS * KNOT_WORDS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRK, ST_TCHK, ST_TDIV, ST_TSQ, ST_TCUBE, ST_THB,
    ST_MRD, ST_MMUL, ST_MACC, ST_ERD, ST_EDAT, ST_EDIV, ST_EMIT
  } state_e;

  state_e       state_q;
  logic [4:0]   pcount_q;
  logic [31:0]  dur_q;
  logic         upd_q;
  logic         anim_q;
  logic [31:0]  start_q [3];
  logic [31:0]  stime_q;
  logic [3:0]   idx_q;
  logic [31:0]  in_w_q [KNOT_WORDS];
  logic [31:0]  elapsed_q;
  logic [2:0]   w_q;
  logic [4:0]   seg_q;
  logic [15:0]  t_q;
  logic [31:0]  tt_q;
  logic [47:0]  ttt_q;
  logic signed [31:0] h_q [4];
  logic [1:0]   j_q;
  logic [1:0]   c_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic [31:0]  pos_q [3];
  logic [31:0]  vel_q [3];
  logic         neg_q;
  logic [1:0]   ev_q;
  logic         vv_q;
  logic         out_valid_q;
  logic [191:0] out_data_q;
  logic [2:0]   out_user_q;

  logic [4:0]   cnt_eff;
  logic [4:0]   nm1;
  logic [31:0]  d_eff;
  logic [36:0]  scaled;
  logic [4:0]   ridx;
  logic [2:0]   roff;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic         we;
  logic [31:0]  rdata;
  logic signed [63:0] acc_d;
  logic signed [33:0] a2, a3, tl;
  logic [31:0]  mag;
  logic         in_acc;
  logic         emit_go;
  div_req_t     div_req;
  logic         div_done;
  logic [DIV_W-1:0] quot;

  always_comb begin
    cnt_eff = pcount_q;
    if (32'(pcount_q) > MAX_POINTS) cnt_eff = 5'(MAX_POINTS);
    if (cnt_eff < 5'd2) cnt_eff = 5'd2;
    nm1    = cnt_eff - 5'd1;
    d_eff  = (dur_q == '0) ? 32'd1 : dur_q;
    scaled = 37'(elapsed_q) * 37'(nm1);
    // segment knots: j[1] selects the far knot, j[0] the tangent
    if (state_q == ST_MRD) begin
      ridx = j_q[1] ? seg_q + 5'd1 : seg_q;
      roff = j_q[0] ? 3'(c_q) + 3'd3 : 3'(c_q);
    end else begin
      ridx = nm1;
      roff = w_q;
    end
    raddr = AW'(32'(ridx) * KNOT_WORDS + 32'(roff));
    waddr = AW'(32'(idx_q) * KNOT_WORDS + 32'(w_q));
    we    = (state_q == ST_WRK);
    acc_d = acc_q + prod_q;
    a2    = 34'(tt_q[31:2]);
    a3    = 34'(ttt_q[47:18]);
    tl    = 34'({t_q, 14'b0});
    mag   = rdata[31] ? (32'd0 - rdata) : rdata;
    in_acc = s_axis_tvalid && s_axis_tready;
    emit_go = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
    div_req.start    = 1'b0;
    div_req.dividend = {scaled[DIV_W-FRAC_W-1:0], 16'b0};
    div_req.divisor  = d_eff;
    if (state_q == ST_TCHK && elapsed_q < d_eff) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_EDAT && w_q >= 3'd3 && upd_q) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(mag);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  hsa_knot_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_w_q[w_q]),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  hsa_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pcount_q    <= POINT_COUNT_RST;
      dur_q       <= DURATION_RST;
      upd_q       <= 1'b0;
      anim_q      <= 1'b0;
      start_q     <= '{default: '0};
      stime_q     <= '0;
      idx_q       <= '0;
      in_w_q      <= '{default: '0};
      elapsed_q   <= '0;
      w_q         <= '0;
      seg_q       <= '0;
      t_q         <= '0;
      tt_q        <= '0;
      ttt_q       <= '0;
      h_q         <= '{default: '0};
      j_q         <= '0;
      c_q         <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      pos_q       <= '{default: '0};
      vel_q       <= '{default: '0};
      neg_q       <= 1'b0;
      ev_q        <= EV_MOVING;
      vv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_POINT_COUNT: pcount_q <= cfg_data_i[4:0];
          CFG_DURATION:    dur_q    <= cfg_data_i;
          CFG_UPDATE_VEL:  upd_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      // the emit state reloads the output register itself
      if (out_valid_q && m_axis_tready && state_q != ST_EMIT) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q <= s_axis_tdata[3:0];
            for (int k = 0; k < KNOT_WORDS; k++) begin
              in_w_q[k] <= s_axis_tdata[4 + 32*k +: 32];
            end
            w_q   <= '0;
            case (s_axis_tuser)
              FUNC_WRITE: begin
                if (32'(s_axis_tdata[3:0]) < MAX_POINTS) state_q <= ST_WRK;
              end
              FUNC_START: begin
                if (!anim_q && pcount_q >= 5'd2) begin
                  for (int k = 0; k < 3; k++) begin
                    start_q[k] <= s_axis_tdata[4 + 32*k +: 32];
                    pos_q[k]   <= s_axis_tdata[4 + 32*k +: 32];
                    vel_q[k]   <= '0;
                  end
                  stime_q <= s_axis_tdata[227:196];
                  anim_q  <= 1'b1;
                  ev_q    <= EV_STARTED;
                  vv_q    <= 1'b0;
                  state_q <= ST_EMIT;
                end
              end
              FUNC_TICK: begin
                if (anim_q) begin
                  elapsed_q <= s_axis_tdata[227:196] - stime_q;
                  state_q   <= ST_TCHK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WRK: begin
          w_q <= w_q + 3'd1;
          if (w_q == 3'(KNOT_WORDS - 1)) state_q <= ST_IDLE;
        end
        ST_TCHK: begin
          state_q <= (elapsed_q < d_eff) ? ST_TDIV : ST_ERD;
        end
        ST_TDIV: begin
          if (div_done) begin
            t_q     <= quot[FRAC_W-1:0];
            seg_q   <= quot[FRAC_W +: 5];
            state_q <= ST_TSQ;
          end
        end
        ST_TSQ: begin
          tt_q    <= 32'(t_q) * 32'(t_q);
          state_q <= ST_TCUBE;
        end
        ST_TCUBE: begin
          ttt_q   <= 48'(tt_q) * 48'(t_q);
          state_q <= ST_THB;
        end
        ST_THB: begin
          h_q[0]  <= 32'(2*a3 - 3*a2 + 34'sd1073741824);
          h_q[1]  <= 32'(a3 - 2*a2 + tl);
          h_q[2]  <= 32'(3*a2 - 2*a3);
          h_q[3]  <= 32'(a3 - a2);
          j_q     <= '0;
          c_q     <= '0;
          acc_q   <= '0;
          state_q <= ST_MRD;
        end
        ST_MRD: state_q <= ST_MMUL;
        ST_MMUL: begin
          prod_q  <= h_q[j_q] * $signed(rdata);
          state_q <= ST_MACC;
        end
        ST_MACC: begin
          if (j_q == 2'd3) begin
            pos_q[c_q] <= acc_d[61:30] + start_q[c_q];
            acc_q      <= '0;
            j_q        <= '0;
            c_q        <= c_q + 2'd1;
            if (c_q == 2'd2) begin
              ev_q    <= EV_MOVING;
              vv_q    <= 1'b0;
              vel_q   <= '{default: '0};
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_MRD;
            end
          end else begin
            acc_q   <= acc_d;
            j_q     <= j_q + 2'd1;
            state_q <= ST_MRD;
          end
        end
        ST_ERD: state_q <= ST_EDAT;
        ST_EDAT: begin
          if (w_q < 3'd3) begin
            pos_q[w_q[1:0]] <= rdata + start_q[w_q[1:0]];
            w_q     <= w_q + 3'd1;
            state_q <= ST_ERD;
          end else if (upd_q) begin
            neg_q   <= rdata[31];
            state_q <= ST_EDIV;
          end else begin
            vel_q[2'(w_q - 3'd3)] <= '0;
            w_q     <= w_q + 3'd1;
            state_q <= (w_q == 3'd5) ? ST_EMIT : ST_ERD;
          end
          ev_q <= EV_STOPPED;
          vv_q <= upd_q;
        end
        ST_EDIV: begin
          if (div_done) begin
            vel_q[2'(w_q - 3'd3)] <= neg_q ? (32'd0 - quot[31:0]) : quot[31:0];
            w_q     <= w_q + 3'd1;
            state_q <= (w_q == 3'd5) ? ST_EMIT : ST_ERD;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
            out_user_q  <= {vv_q, ev_q};
            if (ev_q == EV_STOPPED) anim_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`include "hermite_spline_animator_assert.svh"

  `HSA_ASSERT_NOW(a_mem_wr_only_on_write, we, !anim_q || state_q == ST_WRK, "knot write outside write")
  `HSA_ASSERT_NOW(a_vel_only_on_stop, out_valid_q && out_user_q[2], out_user_q[1:0] == EV_STOPPED, "vel flag w/o stop")
  `HSA_ASSERT_NEXT(a_stop_clears_anim, emit_go && ev_q == EV_STOPPED, !anim_q && out_valid_q, "stop kept anim")
  `HSA_ASSERT_NOW(a_div_done_waited, div_done, state_q == ST_TDIV || state_q == ST_EDIV, "divider result unclaimed")

endmodule

>>> hdl/hsa_knot_mem.sv
module hsa_knot_mem #(
  parameter int DEPTH = 96,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/hsa_div.sv
module hsa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsa_pkg::div_req_t            req_i,
  output logic                         done_o,
  output logic [hsa_pkg::DIV_W-1:0]    quot_o
);
  import hsa_pkg::*;

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [31:0]       rem_q;
  logic [31:0]       den_q;
  logic [DIV_W-1:0]  quot_q;
  logic [32:0]       rem_sh;
  logic [33:0]       diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quot_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den_q};
    ge     = ~diff[33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_o <= 1'b0;
      cnt_q  <= DIV_CW'(DIV_W);
      rem_q  <= '0;
      den_q  <= req_i.divisor;
      quot_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : rem_sh[31:0];
      quot_q <= {quot_q[DIV_W-2:0], ge};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_q <= 1'b0;
        done_o <= 1'b1;
      end
    end else begin
      done_o <= 1'b0;
    end
  end

  assign quot_o = quot_q;

endmodule

>>> bench/hermite_spline_animator_tb.sv
`timescale 1ns / 100ps

module hermite_spline_animator_tb;
  import hsa_pkg::*;

  localparam int NKNOTS      = 16;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 250;
  localparam int RAND_ITEMS  = 1430;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  idx;
    logic [31:0] px, py, pz, tx, ty, tz, now;
  } anim_cmd_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [31:0] x, y, z;
    logic        vv;
    logic [31:0] vx, vy, vz;
  } anim_frame_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  hermite_spline_animator dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] knot_pos [NKNOTS][3];
  logic signed [31:0] knot_tan [NKNOTS][3];
  logic [31:0] anchor [3];
  logic [31:0] t_start = '0;
  logic        running = 1'b0;
  logic [4:0]  pc_reg = POINT_COUNT_RST;
  logic [31:0] dur_reg = DURATION_RST;
  logic        uv_reg = 1'b0;

  anim_cmd_t   cmd_q [$];
  anim_frame_t expected_frames [$];
  int errors = 0, n_moving = 0, n_started = 0, n_stopped = 0, n_vel = 0;

  task automatic add_cmd(input anim_cmd_t c);
    cmd_q = {cmd_q, c};
  endtask

  task automatic predict_anim(input anim_cmd_t c);
    anim_frame_t f;
    logic [31:0] el;
    logic [31:0] px [3];
    logic [31:0] tv [3];
    int n, seg, k;
    longint unsigned d, sc, tf, a2u, a3u;
    longint a2, a3, h00, h10, h01, h11, acc;
    px = '{c.px, c.py, c.pz};
    tv = '{c.tx, c.ty, c.tz};
    f = '0;
    n = (pc_reg > NKNOTS) ? NKNOTS : pc_reg;
    d = (dur_reg == 0) ? 1 : dur_reg;
    case (c.func)
      FUNC_WRITE: begin
        for (k = 0; k < 3; k++) begin
          knot_pos[c.idx][k] = px[k];
          knot_tan[c.idx][k] = tv[k];
        end
      end
      FUNC_START: begin
        if (!running && n >= 2) begin
          anchor = px;
          t_start = c.now;
          running = 1'b1;
          f.ev = EV_STARTED;
          f.x = px[0]; f.y = px[1]; f.z = px[2];
          expected_frames = {expected_frames, f};
        end
      end
      FUNC_TICK: begin
        if (running) begin
          if (n < 2) n = 2;
          el = c.now - t_start;
          if (el < d) begin
            sc = longint'(el) * (n - 1);
            seg = sc / d;
            tf = ((sc % d) << 16) / d;
            a2u = (tf * tf) >> 2;
            a3u = (tf * tf * tf) >> 18;
            a2 = a2u; a3 = a3u;
            h00 = 2 * a3 - 3 * a2 + (longint'(1) << 30);
            h10 = a3 - 2 * a2 + longint'(tf << 14);
            h01 = 3 * a2 - 2 * a3;
            h11 = a3 - a2;
            for (k = 0; k < 3; k++) begin
              acc = h00 * longint'(knot_pos[seg][k]) + h10 * longint'(knot_tan[seg][k])
                  + h01 * longint'(knot_pos[seg+1][k]) + h11 * longint'(knot_tan[seg+1][k]);
              px[k] = acc[61:30] + anchor[k];
            end
            f.ev = EV_MOVING;
          end else begin
            for (k = 0; k < 3; k++) begin
              px[k] = knot_pos[n-1][k] + anchor[k];
              tv[k] = uv_reg ? 32'(longint'(knot_tan[n-1][k]) / longint'(d)) : 32'd0;
            end
            f.ev = EV_STOPPED;
            f.vv = uv_reg;
            f.vx = tv[0]; f.vy = tv[1]; f.vz = tv[2];
            running = 1'b0;
          end
          f.x = px[0]; f.y = px[1]; f.z = px[2];
          expected_frames = {expected_frames, f};
        end
      end
      default: ;
    endcase
  endtask

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    anim_cmd_t c;
    if (s_axis_tvalid && s_axis_tready)
      predict_anim({s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4], s_axis_tdata[67:36],
                    s_axis_tdata[99:68], s_axis_tdata[131:100], s_axis_tdata[163:132],
                    s_axis_tdata[195:164], s_axis_tdata[227:196]});
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        s_axis_tdata <= {4'b0, c.now, c.tz, c.ty, c.tx, c.pz, c.py, c.px, c.idx};
        s_axis_tuser <= c.func;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall mode is redrawn at random among three modes
  int cyc = 0, stall_mode = 0;
  always @(posedge clk_i) begin
    anim_frame_t e;
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(1));
      default: m_axis_tready <= ($urandom_range(3) == 0);
    endcase
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result word, event %0d", m_axis_tuser[1:0]);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        if (m_axis_tuser[1:0] !== e.ev) begin
          $error("event_res exp %0d got %0d", e.ev, m_axis_tuser[1:0]); errors++;
        end
        if (m_axis_tdata[31:0] !== e.x) begin
          $error("out_x exp %h got %h", e.x, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          $error("out_y exp %h got %h", e.y, m_axis_tdata[63:32]); errors++;
        end
        if (m_axis_tdata[95:64] !== e.z) begin
          $error("out_z exp %h got %h", e.z, m_axis_tdata[95:64]); errors++;
        end
        if (m_axis_tuser[2] !== e.vv) begin
          $error("vel_valid exp %0d got %0d", e.vv, m_axis_tuser[2]); errors++;
        end
        if (m_axis_tdata[127:96] !== e.vx) begin
          $error("vel_x exp %h got %h", e.vx, m_axis_tdata[127:96]); errors++;
        end
        if (m_axis_tdata[159:128] !== e.vy) begin
          $error("vel_y exp %h got %h", e.vy, m_axis_tdata[159:128]); errors++;
        end
        if (m_axis_tdata[191:160] !== e.vz) begin
          $error("vel_z exp %h got %h", e.vz, m_axis_tdata[191:160]); errors++;
        end
        case (e.ev)
          EV_MOVING:  n_moving++;
          EV_STARTED: n_started++;
          default:    n_stopped++;
        endcase
        if (e.vv) n_vel++;
      end
    end
  end

  int idle_cnt = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("hermite_spline_animator regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic anim_cmd_t mk_cmd(logic [1:0] fn, logic [3:0] ix, logic [31:0] now);
    anim_cmd_t c;
    c.func = fn; c.idx = ix; c.now = now;
    c.px = pick_word(); c.py = pick_word(); c.pz = pick_word();
    c.tx = pick_word(); c.ty = pick_word(); c.tz = pick_word();
    return c;
  endfunction

  task automatic write_reg(input logic [1:0] ix, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (ix)
      CFG_POINT_COUNT: pc_reg = val[4:0];
      CFG_DURATION:    dur_reg = val;
      default:         uv_reg = val[0];
    endcase
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || s_axis_tvalid || expected_frames.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // mostly start / ticks / overrun sequences with random content, some noise
  task automatic gen_random(input int count);
    int added, k, nt;
    logic [31:0] t0, el;
    longint unsigned d, room;
    added = 0;
    d = (dur_reg == 0) ? 1 : dur_reg;
    while (added < count) begin
      if ($urandom_range(99) < 70) begin
        nt = $urandom_range(0, 2);
        for (k = 0; k < nt; k++) add_cmd(mk_cmd(FUNC_WRITE, 4'($urandom), $urandom));
        t0 = ($urandom_range(3) == 0) ? 32'hffff_ff00 + $urandom_range(255) : $urandom;
        add_cmd(mk_cmd(FUNC_START, 4'($urandom), t0));
        nt = $urandom_range(1, 7);
        for (k = 0; k < nt; k++) begin
          el = (d <= 1) ? 0 : $urandom_range(32'(d - 1), 0);
          if ($urandom_range(7) == 0) add_cmd(mk_cmd(FUNC_WRITE, 4'($urandom), $urandom));
          add_cmd(mk_cmd(FUNC_TICK, 4'($urandom), t0 + el));
        end
        room = 64'hffff_ffff - d;
        if (room > 1000) room = 1000;
        el = 32'(d + $urandom_range(32'(room), 0));
        add_cmd(mk_cmd(FUNC_TICK, 4'($urandom), t0 + el));
        added += nt + 3;
      end else begin
        add_cmd(mk_cmd(2'($urandom_range(3)), 4'($urandom), $urandom));
        added++;
      end
    end
  endtask

  initial begin
    logic [4:0]  pcs [7];
    logic [31:0] durs [7];
    logic        uvs [7];
    anim_cmd_t c;
    int p, k;
    pcs  = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd3, 5'd9};
    durs = '{32'd1, 32'd0, 32'd50, 32'hffff_ffff, 32'd7, 32'd60000, 32'd333};
    uvs  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, default registers: fill every knot, extreme words first
    for (k = 0; k < NKNOTS; k++) begin
      c = mk_cmd(FUNC_WRITE, 4'(k), $urandom);
      if (k == 0) {c.px, c.py, c.pz, c.tx, c.ty, c.tz} = {6{32'h7fff_ffff}};
      if (k == 1) {c.px, c.py, c.pz, c.tx, c.ty, c.tz} = {6{32'h8000_0000}};
      if (k == 2) {c.px, c.py, c.pz, c.tx, c.ty, c.tz} = {6{32'hffff_ffff}};
      add_cmd(c);
    end
    add_cmd(mk_cmd(FUNC_TICK, 4'd0, 32'd5));            // tick while idle
    add_cmd(mk_cmd(2'd3, 4'hf, 32'hffff_ffff));         // unused func
    c = mk_cmd(FUNC_START, 4'd0, 32'hffff_fff0);
    {c.px, c.py, c.pz} = {32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    add_cmd(c);
    add_cmd(mk_cmd(FUNC_START, 4'd0, 32'd0));            // start while running
    add_cmd(mk_cmd(FUNC_TICK, 4'd0, 32'hffff_fff0));     // elapsed 0
    add_cmd(mk_cmd(FUNC_TICK, 4'd0, 32'd500 - 32'd16));  // wrapped elapsed
    add_cmd(mk_cmd(FUNC_TICK, 4'd0, 32'd999 - 32'd16));
    add_cmd(mk_cmd(FUNC_TICK, 4'd0, 32'd1000 - 32'd16)); // reaches duration
    drain();

    for (p = 0; p < 7; p++) begin
      write_reg(CFG_POINT_COUNT, 32'(pcs[p]));
      write_reg(CFG_DURATION, durs[p]);
      write_reg(CFG_UPDATE_VEL, 32'(uvs[p]));
      gen_random(RAND_ITEMS / 7);
      drain();
    end

    $display("covered %0d started, %0d moving, %0d stopped words (%0d with end velocity)",
             n_started, n_moving, n_stopped, n_vel);
    if (errors == 0) begin
      $display("hermite_spline_animator regression: pass");
    end else begin
      $display("hermite_spline_animator regression: fail");
    end
    $finish;
  end

endmodule
